// ===== rtl/fmcb_pkg.sv =====
package fmcb_pkg;

	localparam int NUM_FADERS = 8;
	localparam int FIDX_W     = 3;
	localparam int POS_W      = 14;
	localparam int BYTE_W     = 8;
	localparam int DATA_W     = 7;
	localparam int STEP_W     = 9;

	localparam logic [POS_W-1:0]  POS_MAX    = 14'd16383;
	localparam logic [POS_W-1:0]  POS_RESET  = 14'd12256;
	localparam logic [STEP_W-1:0] STEP_COARSE = 9'd320;
	localparam logic [STEP_W-1:0] STEP_FINE   = 9'd160;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_CC       = 4'hB;

	localparam logic [DATA_W-1:0] CC_LSB_BASE = 7'd32;

	localparam logic [BYTE_W-1:0] ST_CC      = 8'hB0;
	localparam logic [BYTE_W-1:0] ST_NOTE_ON = 8'h90;

	localparam logic [DATA_W-1:0] D_ZONE_SEL  = 7'h0F;
	localparam logic [DATA_W-1:0] D_PORT_SEL  = 7'h2F;
	localparam logic [DATA_W-1:0] D_TOUCH     = 7'h40;
	localparam logic [DATA_W-1:0] D_RELEASE   = 7'h00;
	localparam logic [DATA_W-1:0] D_BANK_ZONE = 7'h0A;
	localparam logic [DATA_W-1:0] D_BANK_RDN  = 7'h42;
	localparam logic [DATA_W-1:0] D_BANK_RUP  = 7'h02;
	localparam logic [DATA_W-1:0] D_NOTE_ZERO = 7'h00;
	localparam logic [DATA_W-1:0] D_VEL_MAX   = 7'h7F;
	localparam logic [3:0]        LSB_CC_HI   = 4'b0100;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam int MSG_IDX_W = 3;

	typedef enum logic [2:0] {
		FUNC_MIDI     = 3'd0,
		FUNC_NUDGE_UP = 3'd1,
		FUNC_NUDGE_DN = 3'd2,
		FUNC_SET      = 3'd3,
		FUNC_BANK_L   = 3'd4,
		FUNC_BANK_R   = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		CMD_MOVE   = 2'd0,
		CMD_PING   = 2'd1,
		CMD_BANK_L = 2'd2,
		CMD_BANK_R = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [FIDX_W-1:0]  fader;
		logic [POS_W-1:0]   value;
	} cmd_t;

endpackage

// ===== rtl/fmcb_front.sv =====
module fmcb_front
	import fmcb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        func,
	input  logic [FIDX_W-1:0] fader_index,
	input  logic [POS_W-1:0]  set_value,
	input  logic [BYTE_W-1:0] midi_status,
	input  logic [DATA_W-1:0] midi_data1,
	input  logic [DATA_W-1:0] midi_data2,
	output logic              push,
	output cmd_t              push_cmd,
	input  logic              push_ready
);

	logic              fine_q;
	logic [POS_W-1:0]  pos_q [NUM_FADERS];

	logic              accept;
	logic [POS_W-1:0]  cur;
	logic [STEP_W-1:0] step;
	logic [POS_W:0]    sum;
	logic [POS_W-1:0]  up_val;
	logic [POS_W-1:0]  dn_val;
	logic [3:0]        kind;
	logic              is_ping;
	logic              msb_hit;
	logic              lsb_hit;
	logic [DATA_W-1:0] lsb_off;
	logic              wr_en;
	logic [FIDX_W-1:0] wr_idx;
	logic [POS_W-1:0]  wr_val;
	logic              fader_ok;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	assign cur    = pos_q[fader_index];
	assign step   = fine_q ? STEP_FINE : STEP_COARSE;
	assign sum    = {1'b0, cur} + {{(POS_W+1-STEP_W){1'b0}}, step};
	assign up_val = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
	assign dn_val = (cur < {{(POS_W-STEP_W){1'b0}}, step}) ? '0
	              : cur - {{(POS_W-STEP_W){1'b0}}, step};

	assign kind     = midi_status[7:4];
	assign is_ping  = (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON)
	               && midi_data1 == D_NOTE_ZERO && midi_data2 == D_NOTE_ZERO;
	assign lsb_off  = midi_data1 - CC_LSB_BASE;
	assign msb_hit  = (kind == KIND_CC) && (int'(midi_data1) < NUM_FADERS);
	assign lsb_hit  = (kind == KIND_CC) && (midi_data1 >= CC_LSB_BASE)
	               && (int'(lsb_off) < NUM_FADERS);
	assign fader_ok = int'(fader_index) < NUM_FADERS;

	always_comb begin
		push           = 1'b0;
		push_cmd.kind  = CMD_MOVE;
		push_cmd.fader = fader_index;
		push_cmd.value = set_value;
		wr_en          = 1'b0;
		wr_idx         = fader_index;
		wr_val         = set_value;
		case (func)
			FUNC_MIDI: begin
				if (is_ping) begin
					push          = in_valid;
					push_cmd.kind = CMD_PING;
				end else if (msb_hit) begin
					wr_en  = 1'b1;
					wr_idx = midi_data1[FIDX_W-1:0];
					wr_val = {midi_data2, pos_q[midi_data1[FIDX_W-1:0]][DATA_W-1:0]};
				end else if (lsb_hit) begin
					wr_en  = 1'b1;
					wr_idx = lsb_off[FIDX_W-1:0];
					wr_val = {pos_q[lsb_off[FIDX_W-1:0]][POS_W-1:DATA_W], midi_data2};
				end
			end
			FUNC_NUDGE_UP, FUNC_NUDGE_DN, FUNC_SET: begin
				if (fader_ok) begin
					wr_en = 1'b1;
					push  = in_valid;
					if (func == FUNC_NUDGE_UP) begin
						wr_val = up_val;
					end else if (func == FUNC_NUDGE_DN) begin
						wr_val = dn_val;
					end
					push_cmd.value = wr_val;
				end
			end
			FUNC_BANK_L: begin
				push          = in_valid;
				push_cmd.kind = CMD_BANK_L;
			end
			FUNC_BANK_R: begin
				push          = in_valid;
				push_cmd.kind = CMD_BANK_R;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fine_q <= 1'b0;
			for (int i = 0; i < NUM_FADERS; i++) begin
				pos_q[i] <= POS_RESET;
			end
		end else begin
			if (cfg_wr_en) begin
				fine_q <= cfg_wr_data;
			end
			if (accept && wr_en) begin
				pos_q[wr_idx] <= wr_val;
			end
		end
	end

endmodule

// ===== rtl/fmcb_queue.sv =====
module fmcb_queue
	import fmcb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = int'(cnt_q) < QDEPTH;
	assign pop_valid  = cnt_q != '0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/fmcb_back.sv =====
module fmcb_back
	import fmcb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  cmd_t              pop_cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_status,
	output logic [DATA_W-1:0] out_data1,
	output logic [DATA_W-1:0] out_data2,
	output logic              last
);

	logic                 busy_q;
	cmd_t                 cmd_q;
	logic [MSG_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    status_q;
	logic [DATA_W-1:0]    d1_q;
	logic [DATA_W-1:0]    d2_q;
	logic                 last_q;

	logic                 slot_free;
	logic                 emit;
	logic [BYTE_W-1:0]    m_status;
	logic [DATA_W-1:0]    m_d1;
	logic [DATA_W-1:0]    m_d2;
	logic                 m_last;
	logic [DATA_W-1:0]    fad;

	assign slot_free = !out_valid_q || out_ready;
	assign emit      = busy_q && slot_free;
	assign pop       = !busy_q;
	assign fad       = {{(DATA_W-FIDX_W){1'b0}}, cmd_q.fader};

	always_comb begin
		m_status = ST_CC;
		m_d1     = D_PORT_SEL;
		m_d2     = D_RELEASE;
		m_last   = 1'b0;
		case (cmd_q.kind)
			CMD_MOVE: begin
				case (idx_q)
					3'd0: begin
						m_d1 = D_ZONE_SEL;
						m_d2 = fad;
					end
					3'd1: m_d2 = D_TOUCH;
					3'd2: begin
						m_d1 = fad;
						m_d2 = cmd_q.value[POS_W-1:DATA_W];
					end
					3'd3: begin
						m_d1 = {LSB_CC_HI, cmd_q.fader};
						m_d2 = cmd_q.value[DATA_W-1:0];
					end
					3'd4: begin
						m_d1 = D_ZONE_SEL;
						m_d2 = fad;
					end
					default: m_last = 1'b1;
				endcase
			end
			CMD_PING: begin
				m_status = ST_NOTE_ON;
				m_d1     = D_NOTE_ZERO;
				m_d2     = D_VEL_MAX;
				m_last   = 1'b1;
			end
			CMD_BANK_L, CMD_BANK_R: begin
				case (idx_q)
					3'd0: begin
						m_d1 = D_ZONE_SEL;
						m_d2 = D_BANK_ZONE;
					end
					3'd1: m_d2 = (cmd_q.kind == CMD_BANK_R) ? D_BANK_RDN : D_TOUCH;
					default: begin
						m_d2   = (cmd_q.kind == CMD_BANK_R) ? D_BANK_RUP : D_RELEASE;
						m_last = 1'b1;
					end
				endcase
			end
			default: m_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (pop_valid) begin
					busy_q <= 1'b1;
					idx_q  <= '0;
				end
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
				if (m_last) begin
					busy_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && pop_valid) begin
			cmd_q <= pop_cmd;
		end
		if (emit) begin
			status_q <= m_status;
			d1_q     <= m_d1;
			d2_q     <= m_d2;
			last_q   <= m_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_data1  = d1_q;
	assign out_data2  = d2_q;
	assign last       = last_q;

endmodule

// ===== rtl/fader_midi_cc_bridge_core.sv =====
// channel   direction  handshake            words
// cfg       in         cfg_wr_en            cfg_wr_data (fine nudge step)
// in        in         in_valid/in_ready    func, fader_index, set_value, midi_*
// out       out        out_valid/out_ready  out_status, out_data1, out_data2, last
// A fader move gives 6 messages at the output, a bank command 3 and a ping reply 1;
// when idle, the back end loads the next command from the two-entry queue.
// The front takes an input word each cycle the queue has room; MIDI fader updates
// and ignored words take no queue slot but still wait for room.
// arst_n clears faders to 12256, fine step off, queue empty, output idle.
// A stalled output holds its word; the queue lets the front keep accepting until it is full.
module fader_midi_cc_bridge_core
	import fmcb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        func,
	input  logic [FIDX_W-1:0] fader_index,
	input  logic [POS_W-1:0]  set_value,
	input  logic [BYTE_W-1:0] midi_status,
	input  logic [DATA_W-1:0] midi_data1,
	input  logic [DATA_W-1:0] midi_data2,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_status,
	output logic [DATA_W-1:0] out_data1,
	output logic [DATA_W-1:0] out_data2,
	output logic              last
);

	logic push;
	cmd_t push_cmd;
	logic push_ready;
	logic pop;
	logic pop_valid;
	cmd_t pop_cmd;

	fmcb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.fader_index (fader_index),
		.set_value   (set_value),
		.midi_status (midi_status),
		.midi_data1  (midi_data1),
		.midi_data2  (midi_data2),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_ready  (push_ready)
	);

	fmcb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd)
	);

	fmcb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_status (out_status),
		.out_data1  (out_data1),
		.out_data2  (out_data2),
		.last       (last)
	);

endmodule

// ===== rtl/fmcb_checker.sv =====
module fmcb_checker
	import fmcb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_status,
	input logic [DATA_W-1:0] out_data1,
	input logic [DATA_W-1:0] out_data2,
	input logic              last
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == ST_CC || out_status == ST_NOTE_ON))
		else $error("unexpected status byte");

	a_ping_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status == ST_NOTE_ON) |->
		(last && out_data1 == D_NOTE_ZERO && out_data2 == D_VEL_MAX))
		else $error("malformed ping reply");

	a_last_release: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && out_status == ST_CC) |-> out_data1 == D_PORT_SEL)
		else $error("run does not end on a port message");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(out_status) && $stable(out_data1)
		 && $stable(out_data2) && $stable(last)))
		else $error("stalled output word changed");

endmodule

bind fader_midi_cc_bridge_core fmcb_checker u_fmcb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_status (out_status),
	.out_data1  (out_data1),
	.out_data2  (out_data2),
	.last       (last)
);

// ===== test/fader_midi_cc_bridge_core_tb.sv =====
`timescale 1ns / 1ps

module fader_midi_cc_bridge_core_tb;
	import fmcb_pkg::*;

	localparam logic [7:0] STAT_CC        = 8'hB0;
	localparam logic [7:0] STAT_NOTE_ON   = 8'h90;
	localparam logic [6:0] CTL_ZONE       = 7'h0F;
	localparam logic [6:0] CTL_PORT       = 7'h2F;
	localparam logic [6:0] PORT_TOUCH     = 7'h40;
	localparam logic [6:0] PORT_RELEASE   = 7'h00;
	localparam logic [6:0] ZONE_BANK      = 7'h0A;
	localparam logic [6:0] BANK_RIGHT_DN  = 7'h42;
	localparam logic [6:0] BANK_RIGHT_UP  = 7'h02;
	localparam logic [6:0] NOTE_ZERO      = 7'h00;
	localparam logic [6:0] VEL_FULL       = 7'h7F;
	localparam int         CTL_LSB_BASE   = 32;
	localparam int         POS_TOP        = 16383;
	localparam int         POS_HOME       = 12256;
	localparam int         NUDGE_COARSE   = 320;
	localparam int         NUDGE_FINE     = 160;
	localparam int         SETTLE_CYCLES  = 12;
	localparam int         WORDS_PER_PASS = 37;
	localparam logic [2:0] FUNC_RSVD6     = 3'd6;
	localparam logic [2:0] FUNC_RSVD7     = 3'd7;

	typedef enum logic [1:0] {
		ENT_WORD,
		ENT_STEP,
		ENT_DRAIN
	} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		logic [2:0]  func;
		logic [2:0]  fidx;
		logic [13:0] sv;
		logic [7:0]  st;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic        fine;
		int unsigned gap;
	} entry_t;

	typedef struct packed {
		logic [7:0] st;
		logic [6:0] d1;
		logic [6:0] d2;
		logic       lst;
	} msg_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic              cfg_wr_data = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        func = '0;
	logic [FIDX_W-1:0] fader_index = '0;
	logic [POS_W-1:0]  set_value = '0;
	logic [BYTE_W-1:0] midi_status = '0;
	logic [DATA_W-1:0] midi_data1 = '0;
	logic [DATA_W-1:0] midi_data2 = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] out_status;
	logic [DATA_W-1:0] out_data1;
	logic [DATA_W-1:0] out_data2;
	logic              last;

	entry_t      word_queue[$];
	msg_t        expected_msgs[$];
	entry_t      cur_word;
	logic [13:0] fader_pos [NUM_FADERS];
	logic        fine_step;
	int unsigned wait_cnt;
	int unsigned stall_cnt;
	int unsigned stall_draw;
	bit          tx_burst;
	bit          rx_burst;
	int          mismatches;
	int          msg_count;
	msg_t        want_msg;

	fader_midi_cc_bridge_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.fader_index (fader_index),
		.set_value   (set_value),
		.midi_status (midi_status),
		.midi_data1  (midi_data1),
		.midi_data2  (midi_data2),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_status  (out_status),
		.out_data1   (out_data1),
		.out_data2   (out_data2),
		.last        (last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Some tests failed");
		$finish;
	end

	task automatic push_msg(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2,
			input logic lst);
		msg_t m;
		m.st = st;
		m.d1 = d1;
		m.d2 = d2;
		m.lst = lst;
		expected_msgs.push_back(m);
	endtask

	task automatic predict_fader_move(input logic [2:0] f, input logic [13:0] pos);
		push_msg(STAT_CC, CTL_ZONE, {4'b0, f}, 1'b0);
		push_msg(STAT_CC, CTL_PORT, PORT_TOUCH, 1'b0);
		push_msg(STAT_CC, {4'b0, f}, pos[13:7], 1'b0);
		push_msg(STAT_CC, 7'(CTL_LSB_BASE) | {4'b0, f}, pos[6:0], 1'b0);
		push_msg(STAT_CC, CTL_ZONE, {4'b0, f}, 1'b0);
		push_msg(STAT_CC, CTL_PORT, PORT_RELEASE, 1'b1);
	endtask

	task automatic predict_word(input entry_t w);
		int pos;
		int step;
		logic [3:0] kind;
		step = fine_step ? NUDGE_FINE : NUDGE_COARSE;
		kind = w.st[7:4];
		case (w.func)
			FUNC_MIDI: begin
				if ((kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) && w.d1 == 0 && w.d2 == 0) begin
					push_msg(STAT_NOTE_ON, NOTE_ZERO, VEL_FULL, 1'b1);
				end else if (kind == KIND_CC) begin
					if (w.d1 < NUM_FADERS)
						fader_pos[w.d1][13:7] = w.d2;
					else if (w.d1 >= CTL_LSB_BASE && w.d1 < CTL_LSB_BASE + NUM_FADERS)
						fader_pos[w.d1 - CTL_LSB_BASE][6:0] = w.d2;
				end
			end
			FUNC_NUDGE_UP, FUNC_NUDGE_DN, FUNC_SET: begin
				if (w.fidx < NUM_FADERS) begin
					pos = fader_pos[w.fidx];
					if (w.func == FUNC_NUDGE_UP)
						pos = (pos + step > POS_TOP) ? POS_TOP : pos + step;
					else if (w.func == FUNC_NUDGE_DN)
						pos = (pos < step) ? 0 : pos - step;
					else
						pos = w.sv;
					fader_pos[w.fidx] = pos[13:0];
					predict_fader_move(w.fidx, pos[13:0]);
				end
			end
			FUNC_BANK_L: begin
				push_msg(STAT_CC, CTL_ZONE, ZONE_BANK, 1'b0);
				push_msg(STAT_CC, CTL_PORT, PORT_TOUCH, 1'b0);
				push_msg(STAT_CC, CTL_PORT, PORT_RELEASE, 1'b1);
			end
			FUNC_BANK_R: begin
				push_msg(STAT_CC, CTL_ZONE, ZONE_BANK, 1'b0);
				push_msg(STAT_CC, CTL_PORT, BANK_RIGHT_DN, 1'b0);
				push_msg(STAT_CC, CTL_PORT, BANK_RIGHT_UP, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at message %0d, %s: got 0x%0h, want 0x%0h",
			msg_count, what, got, want);
	endtask

	// driver: present queued words, hold until taken, apply step changes once drained
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_wr_en <= 1'b0;
			cfg_wr_data <= 1'b0;
			func <= '0;
			fader_index <= '0;
			set_value <= '0;
			midi_status <= '0;
			midi_data1 <= '0;
			midi_data2 <= '0;
			wait_cnt <= 0;
			foreach (fader_pos[i])
				fader_pos[i] = 14'(POS_HOME);
			fine_step = 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_word(cur_word);
			if (in_valid && !in_ready) begin
			end else if (word_queue.size() == 0) begin
				in_valid <= 1'b0;
				cfg_wr_en <= 1'b0;
			end else if (word_queue[0].kind == ENT_WORD) begin
				cfg_wr_en <= 1'b0;
				if (wait_cnt < word_queue[0].gap) begin
					wait_cnt <= wait_cnt + 1;
					in_valid <= 1'b0;
				end else begin
					cur_word = word_queue.pop_front();
					in_valid <= 1'b1;
					func <= cur_word.func;
					fader_index <= cur_word.fidx;
					set_value <= cur_word.sv;
					midi_status <= cur_word.st;
					midi_data1 <= cur_word.d1;
					midi_data2 <= cur_word.d2;
					wait_cnt <= 0;
				end
			end else begin
				in_valid <= 1'b0;
				if (expected_msgs.size() != 0) begin
					wait_cnt <= 0;
					cfg_wr_en <= 1'b0;
				end else if (wait_cnt < SETTLE_CYCLES) begin
					wait_cnt <= wait_cnt + 1;
					cfg_wr_en <= 1'b0;
				end else begin
					wait_cnt <= 0;
					if (word_queue[0].kind == ENT_STEP) begin
						cfg_wr_en <= 1'b1;
						cfg_wr_data <= word_queue[0].fine;
						fine_step = word_queue[0].fine;
					end else begin
						cfg_wr_en <= 1'b0;
					end
					void'(word_queue.pop_front());
				end
			end
		end
	end

	// monitor: check each word taken at the output, then draw the next stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt <= 0;
			rx_burst = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_msgs.size() == 0) begin
					report_mismatch("word with none expected, status", int'(out_status), 0);
				end else begin
					want_msg = expected_msgs.pop_front();
					if (out_status !== want_msg.st)
						report_mismatch("out_status", int'(out_status), int'(want_msg.st));
					if (out_data1 !== want_msg.d1)
						report_mismatch("out_data1", int'(out_data1), int'(want_msg.d1));
					if (out_data2 !== want_msg.d2)
						report_mismatch("out_data2", int'(out_data2), int'(want_msg.d2));
					if (last !== want_msg.lst)
						report_mismatch("last", int'(last), int'(want_msg.lst));
				end
				msg_count++;
				if ($urandom_range(0, 29) == 0)
					rx_burst = !rx_burst;
				stall_draw = rx_burst ? 0 : $urandom_range(0, 9);
				stall_cnt <= stall_draw;
				out_ready <= (stall_draw == 0);
			end else if (stall_cnt != 0) begin
				stall_cnt <= stall_cnt - 1;
				out_ready <= (stall_cnt == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic entry_t rand_word();
		entry_t w;
		w.kind = ENT_WORD;
		w.func = 3'($urandom);
		w.fidx = 3'($urandom);
		w.sv = 14'($urandom);
		w.st = 8'($urandom);
		w.d1 = 7'($urandom);
		w.d2 = 7'($urandom);
		w.fine = 1'b0;
		w.gap = tx_burst ? 0 : $urandom_range(0, 9);
		return w;
	endfunction

	task automatic queue_move(input logic [2:0] fn, input logic [2:0] f, input logic [13:0] sv);
		entry_t w;
		w = rand_word();
		w.func = fn;
		w.fidx = f;
		w.sv = sv;
		word_queue.push_back(w);
	endtask

	task automatic queue_midi(input logic [7:0] st, input logic [6:0] d1, input logic [6:0] d2);
		entry_t w;
		w = rand_word();
		w.func = FUNC_MIDI;
		w.st = st;
		w.d1 = d1;
		w.d2 = d2;
		word_queue.push_back(w);
	endtask

	task automatic queue_marker(input entry_kind_t kind, input logic fine);
		entry_t w;
		w = rand_word();
		w.kind = kind;
		w.fine = fine;
		word_queue.push_back(w);
	endtask

	initial begin
		int counted;
		int r;
		int n;
		logic [2:0] f;
		logic [2:0] fn;
		logic [7:0] st;
		logic [6:0] d1;
		logic [6:0] d2;

		arst_n = 1'b0;
		tx_burst = 1'b0;

		queue_marker(ENT_STEP, 1'b0);
		queue_move(FUNC_SET, 3'd0, 14'd0);
		queue_move(FUNC_NUDGE_DN, 3'd0, 14'h3FFF);
		queue_move(FUNC_NUDGE_UP, 3'd0, 14'd0);
		queue_move(FUNC_SET, 3'd7, 14'h3FFF);
		queue_move(FUNC_NUDGE_UP, 3'd7, 14'd0);
		queue_move(FUNC_NUDGE_DN, 3'd7, 14'h3FFF);
		queue_move(FUNC_SET, 3'd3, 14'h2AAA);
		queue_move(FUNC_SET, 3'd4, 14'h1555);
		queue_move(FUNC_BANK_L, 3'd0, 14'd0);
		queue_move(FUNC_BANK_R, 3'd7, 14'h3FFF);
		queue_midi(8'h80, 7'd0, 7'd0);
		queue_midi(8'h9F, 7'd0, 7'd0);
		queue_midi(8'h85, 7'd0, 7'd1);
		queue_midi(8'h90, 7'd1, 7'd0);
		queue_midi(8'hBF, 7'd7, 7'h7F);
		queue_midi(8'hB0, 7'd39, 7'd0);
		queue_midi(8'hB3, 7'd8, 7'h55);
		queue_midi(8'hB4, 7'd31, 7'h2A);
		queue_midi(8'hB5, 7'd40, 7'h7F);
		queue_midi(8'hBA, 7'h7F, 7'h7F);
		queue_move(FUNC_NUDGE_UP, 3'd7, 14'd0);
		queue_midi(8'h00, 7'h7F, 7'h7F);
		queue_midi(8'hFF, 7'd0, 7'd0);
		queue_move(FUNC_RSVD6, 3'd2, 14'd0);
		queue_move(FUNC_RSVD7, 3'd5, 14'h3FFF);

		queue_marker(ENT_STEP, 1'b1);
		queue_move(FUNC_SET, 3'd1, 14'd100);
		queue_move(FUNC_NUDGE_DN, 3'd1, 14'd0);
		queue_move(FUNC_NUDGE_UP, 3'd1, 14'd0);
		queue_move(FUNC_SET, 3'd2, 14'd16300);
		queue_move(FUNC_NUDGE_UP, 3'd2, 14'd0);

		counted = 0;
		for (int pass = 0; pass < 4; pass++) begin
			queue_marker(ENT_STEP, pass[0]);
			tx_burst = $urandom_range(0, 1);
			while (counted < WORDS_PER_PASS * (pass + 1)) begin
				if ($urandom_range(0, 24) == 0)
					tx_burst = !tx_burst;
				if (pass == 2 && counted == WORDS_PER_PASS * 2 + 20)
					queue_marker(ENT_DRAIN, 1'b0);
				r = $urandom_range(0, 99);
				f = 3'($urandom);
				if (r < 25) begin
					n = $urandom_range(0, 99);
					st = 8'($urandom);
					d1 = 7'($urandom);
					d2 = 7'($urandom);
					if (n < 40) begin
						st[7:4] = KIND_CC;
						d1 = $urandom_range(0, 1) ? {4'b0, f} : 7'(CTL_LSB_BASE) | {4'b0, f};
					end else if (n < 55) begin
						st[7:4] = $urandom_range(0, 1) ? KIND_NOTE_OFF : KIND_NOTE_ON;
						d1 = 7'd0;
						d2 = 7'd0;
					end else if (n < 70) begin
						st[7:4] = KIND_CC;
						d1 = $urandom_range(0, 1) ? 7'($urandom_range(8, 31))
							: 7'($urandom_range(40, 127));
					end else if (n < 85) begin
						st[7:4] = $urandom_range(0, 1) ? KIND_NOTE_OFF : KIND_NOTE_ON;
						if (d1 == 0 && d2 == 0)
							d2 = 7'd1;
					end
					queue_midi(st, d1, d2);
					counted++;
				end else if (r < 43) begin
					queue_move(FUNC_NUDGE_UP, f, 14'($urandom));
					counted++;
				end else if (r < 61) begin
					queue_move(FUNC_NUDGE_DN, f, 14'($urandom));
					counted++;
				end else if (r < 73) begin
					n = $urandom_range(0, 7);
					queue_move(FUNC_SET, f, n == 0 ? 14'd0 : n == 1 ? 14'h3FFF : 14'($urandom));
					counted++;
				end else if (r < 80) begin
					// host writes both halves, then a local nudge or set follows on the same fader
					queue_midi({KIND_CC, 4'($urandom)}, {4'b0, f}, 7'($urandom));
					queue_midi({KIND_CC, 4'($urandom)}, 7'(CTL_LSB_BASE) | {4'b0, f},
						7'($urandom));
					queue_move(3'($urandom_range(1, 3)), f, 14'($urandom));
					counted += 3;
				end else if (r < 88) begin
					// run a fader toward its end stop
					fn = $urandom_range(0, 1) ? FUNC_NUDGE_UP : FUNC_NUDGE_DN;
					n = $urandom_range(3, 6);
					if ($urandom_range(0, 1)) begin
						queue_move(FUNC_SET, f, (fn == FUNC_NUDGE_UP) ? 14'd16200 : 14'd200);
						counted++;
					end
					repeat (n)
						queue_move(fn, f, 14'($urandom));
					counted += n;
				end else if (r < 95) begin
					queue_move($urandom_range(0, 1) ? FUNC_BANK_L : FUNC_BANK_R, f,
						14'($urandom));
					counted++;
				end else begin
					queue_move($urandom_range(0, 1) ? FUNC_RSVD6 : FUNC_RSVD7, f,
						14'($urandom));
					counted++;
				end
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (word_queue.size() != 0 || in_valid || expected_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
